// ----- rtl/orbit_camera_eye_update_top_assert.svh -----
// Assertion macros shared by the orbit camera eye update RTL.
`ifndef ORBIT_CAMERA_EYE_UPDATE_TOP_ASSERT_SVH
`define ORBIT_CAMERA_EYE_UPDATE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OCE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/oce_pkg.sv -----
// Types and constants of the orbit camera eye update block.
package oce_pkg;

  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned XY_W = 33;
  localparam int unsigned Z_W = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [15:0] TURN_RATE_RST = 16'd402;
  localparam logic signed [14:0] PITCH_UPPER_RST = 15'sd3217;
  localparam logic signed [14:0] PITCH_LOWER_RST = -15'sd3217;
  localparam logic [30:0] DISTANCE_RST = 31'd655360;

  localparam logic signed [32:0] Q28_PI = 33'sd843314857;
  localparam logic signed [32:0] Q28_TWO_PI = 33'sd1686629713;
  localparam logic signed [32:0] Q28_HALF_PI = 33'sd421657428;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [16:0] Q12_PI = 17'sd12868;
  localparam logic signed [16:0] Q12_TWO_PI = 17'sd25736;

  localparam logic signed [Z_W-1:0] ATAN_Q28 [CORDIC_STEPS] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109,
    32'sd1048571, 32'sd524287, 32'sd262144, 32'sd131072,
    32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
    32'sd4096, 32'sd2048, 32'sd1024, 32'sd512,
    32'sd256, 32'sd128, 32'sd64, 32'sd32
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TURN_RATE   = 2'd0,
    CFG_PITCH_UPPER = 2'd1,
    CFG_PITCH_LOWER = 2'd2,
    CFG_DISTANCE    = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_MPITCH,
    S_MYAW,
    S_FEED_P,
    S_FEED_Y,
    S_WAIT,
    S_MCS,
    S_MCC,
    S_ME0,
    S_ME1,
    S_ME2,
    S_FIN
  } state_e;

  typedef struct packed {
    logic                   vld;
    logic                   tag;
    logic                   flip;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

endpackage

// ----- rtl/oce_if.sv -----
// Valid/ready channel interfaces for the input and result beats.
interface oce_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] stick_horizontal;
  logic signed [15:0] stick_vertical;
  logic [15:0]        frame_time;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;

  modport source (
    output valid, stick_horizontal, stick_vertical, frame_time,
    output target_x, target_y, target_z,
    input  ready
  );
  modport sink (
    input  valid, stick_horizontal, stick_vertical, frame_time,
    input  target_x, target_y, target_z,
    output ready
  );
endinterface

interface oce_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [15:0] pitch_now;
  logic signed [15:0] yaw_now;

  modport source (
    output valid, eye_x, eye_y, eye_z, pitch_now, yaw_now,
    input  ready
  );
  modport sink (
    input  valid, eye_x, eye_y, eye_z, pitch_now, yaw_now,
    output ready
  );
endinterface

// ----- rtl/oce_cordic_cell.sv -----
// One CORDIC rotation cell of the sine and cosine chain.
module oce_cordic_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  oce_pkg::cordic_t cell_i,
  output oce_pkg::cordic_t cell_o
);

  logic signed [oce_pkg::XY_W-1:0] x_s, y_s, x_d, y_d, x_q, y_q;
  logic signed [oce_pkg::Z_W-1:0]  z_s, z_d, z_q;
  logic                            vld_q, tag_q, flip_q;

  assign x_s = cell_i.x;
  assign y_s = cell_i.y;
  assign z_s = cell_i.z;

  always_comb begin
    if (z_s >= 0) begin
      x_d = x_s - (y_s >>> Idx);
      y_d = y_s + (x_s >>> Idx);
      z_d = z_s - oce_pkg::ATAN_Q28[Idx];
    end else begin
      x_d = x_s + (y_s >>> Idx);
      y_d = y_s - (x_s >>> Idx);
      z_d = z_s + oce_pkg::ATAN_Q28[Idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= cell_i.tag;
    flip_q <= cell_i.flip;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign cell_o = '{vld: vld_q, tag: tag_q, flip: flip_q, x: x_q, y: y_q, z: z_q};

endmodule

// ----- rtl/orbit_camera_eye_update_top.sv -----
// Orbit camera eye update: angle step, CORDIC cell chain, direction and eye point.
// An input beat is taken only in the idle state: each item passes the 24-cell
// CORDIC chain and the eight products that share the single 33 x 33 multiplier
// before the next input beat is accepted.
// Reset clears both angles, loads the register defaults and empties the chain.
module orbit_camera_eye_update_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [oce_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [oce_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  oce_in_if.sink                            in_i,
  oce_out_if.source                         out_o
);

  `include "orbit_camera_eye_update_top_assert.svh"

  localparam int unsigned NSTEP = oce_pkg::CORDIC_STEPS;
  localparam logic signed [65:0] RND30 = 66'sd536870912;
  localparam logic signed [65:0] RND27 = 66'sd67108864;

  oce_pkg::state_e state_q, state_d;

  logic [15:0]        turn_rate_q;
  logic signed [14:0] pitch_upper_q, pitch_lower_q;
  logic [30:0]        distance_q;

  logic signed [15:0] pitch_q, yaw_q;
  logic signed [15:0] sh_q, sv_q;
  logic [15:0]        ft_q;
  logic signed [31:0] tx_q, ty_q, tz_q;
  logic [31:0]        step_q;

  logic signed [32:0] sp_q, cp_q, sy_q, cy_q, dir0_q, dir2_q;
  logic signed [31:0] ex_q, ey_q;

  logic signed [32:0] mul_a, mul_b;
  logic               mul_en;
  logic signed [65:0] prod_q;
  logic signed [65:0] p30_full, p27_full;
  logic signed [35:0] p30;
  logic signed [21:0] delta;

  logic               in_ready;
  logic               fin_go;
  logic               feed_vld, feed_tag;

  logic               out_vld_q;
  logic signed [31:0] out_x_q, out_y_q, out_z_q;
  logic signed [15:0] out_p_q, out_y_ang_q;

  oce_pkg::cordic_t   prep_d, prep_q;
  oce_pkg::cordic_t   chain [NSTEP+1];
  logic [NSTEP:0]     chain_vld;

  logic signed [15:0] feed_ang;
  logic signed [32:0] z0, zw, s_out, c_out;
  logic signed [15:0] p_clamp1, p_clamp2, lim_up, lim_lo;
  logic signed [16:0] y_w1, y_w2;

  function automatic logic signed [15:0] sat16(input logic signed [22:0] v);
    if (v > 23'sd32767) begin
      return 16'sd32767;
    end else if (v < -23'sd32768) begin
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_rate_q   <= oce_pkg::TURN_RATE_RST;
      pitch_upper_q <= oce_pkg::PITCH_UPPER_RST;
      pitch_lower_q <= oce_pkg::PITCH_LOWER_RST;
      distance_q    <= oce_pkg::DISTANCE_RST;
    end else if (cfg_we_i) begin
      unique case (oce_pkg::cfg_idx_e'(cfg_idx_i))
        oce_pkg::CFG_TURN_RATE:   turn_rate_q   <= cfg_data_i[15:0];
        oce_pkg::CFG_PITCH_UPPER: pitch_upper_q <= cfg_data_i[14:0];
        oce_pkg::CFG_PITCH_LOWER: pitch_lower_q <= cfg_data_i[14:0];
        oce_pkg::CFG_DISTANCE:    distance_q    <= cfg_data_i[30:0];
        default:                  turn_rate_q   <= turn_rate_q;
      endcase
    end
  end

  assign fin_go = !out_vld_q || out_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      oce_pkg::S_IDLE:   if (in_i.valid) state_d = oce_pkg::S_STEP;
      oce_pkg::S_STEP:   state_d = oce_pkg::S_MPITCH;
      oce_pkg::S_MPITCH: state_d = oce_pkg::S_MYAW;
      oce_pkg::S_MYAW:   state_d = oce_pkg::S_FEED_P;
      oce_pkg::S_FEED_P: state_d = oce_pkg::S_FEED_Y;
      oce_pkg::S_FEED_Y: state_d = oce_pkg::S_WAIT;
      oce_pkg::S_WAIT:   if (chain[NSTEP].vld && chain[NSTEP].tag) state_d = oce_pkg::S_MCS;
      oce_pkg::S_MCS:    state_d = oce_pkg::S_MCC;
      oce_pkg::S_MCC:    state_d = oce_pkg::S_ME0;
      oce_pkg::S_ME0:    state_d = oce_pkg::S_ME1;
      oce_pkg::S_ME1:    state_d = oce_pkg::S_ME2;
      oce_pkg::S_ME2:    state_d = oce_pkg::S_FIN;
      oce_pkg::S_FIN:    if (fin_go) state_d = oce_pkg::S_IDLE;
      default:           state_d = oce_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oce_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Controls: multiplier operands, chain feed and input ready.
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_en   = 1'b0;
    feed_vld = 1'b0;
    feed_tag = 1'b0;
    feed_ang = pitch_q;
    in_ready = 1'b0;
    unique case (state_q)
      oce_pkg::S_IDLE: in_ready = 1'b1;
      oce_pkg::S_STEP: begin
        mul_a  = {17'd0, turn_rate_q};
        mul_b  = {17'd0, ft_q};
        mul_en = 1'b1;
      end
      oce_pkg::S_MPITCH: begin
        mul_a  = 33'(sv_q);
        mul_b  = {1'b0, prod_q[31:0]};
        mul_en = 1'b1;
      end
      oce_pkg::S_MYAW: begin
        mul_a  = 33'(sh_q);
        mul_b  = {1'b0, step_q};
        mul_en = 1'b1;
      end
      oce_pkg::S_FEED_P: feed_vld = 1'b1;
      oce_pkg::S_FEED_Y: begin
        feed_vld = 1'b1;
        feed_tag = 1'b1;
        feed_ang = yaw_q;
      end
      oce_pkg::S_MCS: begin
        mul_a  = cp_q;
        mul_b  = sy_q;
        mul_en = 1'b1;
      end
      oce_pkg::S_MCC: begin
        mul_a  = cp_q;
        mul_b  = cy_q;
        mul_en = 1'b1;
      end
      oce_pkg::S_ME0: begin
        mul_a  = dir0_q;
        mul_b  = {2'b00, distance_q};
        mul_en = 1'b1;
      end
      oce_pkg::S_ME1: begin
        mul_a  = -sp_q;
        mul_b  = {2'b00, distance_q};
        mul_en = 1'b1;
      end
      oce_pkg::S_ME2: begin
        mul_a  = dir2_q;
        mul_b  = {2'b00, distance_q};
        mul_en = 1'b1;
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  assign p30_full = (prod_q + RND30) >>> 30;
  assign p27_full = (prod_q + RND27) >>> 27;
  assign p30      = p30_full[35:0];
  assign delta    = p27_full[21:0];

  // Angle reduction into the first cell.
  always_comb begin
    z0 = {feed_ang[15], feed_ang, 16'd0};
    if (z0 > oce_pkg::Q28_PI) begin
      zw = z0 - oce_pkg::Q28_TWO_PI;
    end else if (z0 < -oce_pkg::Q28_PI) begin
      zw = z0 + oce_pkg::Q28_TWO_PI;
    end else begin
      zw = z0;
    end
    prep_d.vld  = feed_vld;
    prep_d.tag  = feed_tag;
    prep_d.x    = oce_pkg::CORDIC_GAIN;
    prep_d.y    = '0;
    prep_d.flip = 1'b0;
    prep_d.z    = zw[31:0];
    if (zw > oce_pkg::Q28_HALF_PI) begin
      prep_d.z    = 32'(zw - oce_pkg::Q28_PI);
      prep_d.flip = 1'b1;
    end else if (zw < -oce_pkg::Q28_HALF_PI) begin
      prep_d.z    = 32'(zw + oce_pkg::Q28_PI);
      prep_d.flip = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_q <= '0;
    end else begin
      prep_q <= prep_d;
    end
  end

  assign chain[0]     = prep_q;
  assign chain_vld[0] = chain[0].vld;

  for (genvar k = 0; k < NSTEP; k++) begin : g_cell
    oce_cordic_cell #(
      .Idx(k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cell_i(chain[k]),
      .cell_o(chain[k+1])
    );
    assign chain_vld[k+1] = chain[k+1].vld;
  end

  assign s_out = chain[NSTEP].flip ? -chain[NSTEP].y : chain[NSTEP].y;
  assign c_out = chain[NSTEP].flip ? -chain[NSTEP].x : chain[NSTEP].x;

  // Limits on pitch and the wrap of yaw.
  assign lim_up   = 16'(pitch_upper_q);
  assign lim_lo   = 16'(pitch_lower_q);
  assign p_clamp1 = (pitch_q > lim_up) ? lim_up : pitch_q;
  assign p_clamp2 = (p_clamp1 < lim_lo) ? lim_lo : p_clamp1;
  assign y_w1     = (17'(yaw_q) < -oce_pkg::Q12_PI) ? 17'(yaw_q) + oce_pkg::Q12_TWO_PI
                                                    : 17'(yaw_q);
  assign y_w2     = (y_w1 > oce_pkg::Q12_PI) ? y_w1 - oce_pkg::Q12_TWO_PI : y_w1;

  // Angle state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= '0;
      yaw_q   <= '0;
    end else begin
      if (state_q == oce_pkg::S_MYAW) begin
        pitch_q <= sat16(23'(pitch_q) + 23'(delta));
      end
      if (state_q == oce_pkg::S_FEED_P) begin
        yaw_q <= sat16(23'(yaw_q) + 23'(delta));
      end
      if (state_q == oce_pkg::S_FIN && fin_go) begin
        pitch_q <= p_clamp2;
        yaw_q   <= y_w2[15:0];
      end
    end
  end

  // Datapath holding registers.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      sh_q <= in_i.stick_horizontal;
      sv_q <= in_i.stick_vertical;
      ft_q <= in_i.frame_time;
      tx_q <= in_i.target_x;
      ty_q <= in_i.target_y;
      tz_q <= in_i.target_z;
    end
    if (state_q == oce_pkg::S_MPITCH) begin
      step_q <= prod_q[31:0];
    end
    if (state_q == oce_pkg::S_WAIT && chain[NSTEP].vld) begin
      if (chain[NSTEP].tag) begin
        sy_q <= s_out;
        cy_q <= c_out;
      end else begin
        sp_q <= s_out;
        cp_q <= c_out;
      end
    end
    if (state_q == oce_pkg::S_MCC) begin
      dir0_q <= p30[32:0];
    end
    if (state_q == oce_pkg::S_ME0) begin
      dir2_q <= p30[32:0];
    end
    if (state_q == oce_pkg::S_ME1) begin
      ex_q <= sat32(36'(tx_q) + p30);
    end
    if (state_q == oce_pkg::S_ME2) begin
      ey_q <= sat32(36'(ty_q) + p30);
    end
    if (state_q == oce_pkg::S_FIN && fin_go) begin
      out_x_q     <= ex_q;
      out_y_q     <= ey_q;
      out_z_q     <= sat32(36'(tz_q) + p30);
      out_p_q     <= p_clamp2;
      out_y_ang_q <= y_w2[15:0];
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == oce_pkg::S_FIN && fin_go) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_vld_q;
  assign out_o.eye_x     = out_x_q;
  assign out_o.eye_y     = out_y_q;
  assign out_o.eye_z     = out_z_q;
  assign out_o.pitch_now = out_p_q;
  assign out_o.yaw_now   = out_y_ang_q;

  `OCE_ASSERT_IMPL(a_yaw_wrapped, clk_i, rst_ni, out_vld_q,
    (out_y_ang_q <= 16'sd12868) && (out_y_ang_q >= -16'sd12868),
    "yaw result beat outside the wrapped range")
  `OCE_ASSERT_IMPL(a_chain_out_in_wait, clk_i, rst_ni, chain[NSTEP].vld,
    state_q == oce_pkg::S_WAIT, "CORDIC chain produced a result outside the wait state")
  `OCE_ASSERT_IMPL(a_idle_chain_empty, clk_i, rst_ni, state_q == oce_pkg::S_IDLE,
    chain_vld == '0, "CORDIC chain not empty while idle")
  `OCE_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_i.valid && in_ready,
    state_q == oce_pkg::S_STEP, "accepted input beat did not start the step product")

endmodule

// ----- test/orbit_camera_eye_update_top_tb.sv -----
// Self-checking testbench of the orbit camera eye update block with a fixed-point predictor.
`timescale 1ns / 1ps

module orbit_camera_eye_update_top_tb;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASES = 8;
  localparam int unsigned FRAMES_PER_PHASE = 125;
  localparam longint EYE_MIN = -64'sd2147483648;
  localparam longint EYE_MAX = 64'sd2147483647;
  localparam longint ANGLE_MIN = -64'sd32768;
  localparam longint ANGLE_MAX = 64'sd32767;
  localparam logic signed [15:0] STICK_MAX = 16'sh7fff;
  localparam logic signed [15:0] STICK_MIN = 16'sh8000;
  localparam logic signed [31:0] COORD_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] COORD_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [15:0] stick_h;
    logic signed [15:0] stick_v;
    logic [15:0]        frame_time;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } frame_t;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } eye_t;

  class orbit_eye_board;
    longint turn_rate;
    longint pitch_hi;
    longint pitch_lo;
    longint distance;
    longint pitch;
    longint yaw;
    eye_t   eyes_due[$];
    int     faults;

    function new();
      turn_rate = longint'(oce_pkg::TURN_RATE_RST);
      pitch_hi  = longint'(oce_pkg::PITCH_UPPER_RST);
      pitch_lo  = longint'(oce_pkg::PITCH_LOWER_RST);
      distance  = longint'(oce_pkg::DISTANCE_RST);
      pitch     = 64'sd0;
      yaw       = 64'sd0;
      faults    = 0;
    endfunction

    function void set_reg(oce_pkg::cfg_idx_e idx, logic [oce_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        oce_pkg::CFG_TURN_RATE:   turn_rate = longint'(data[15:0]);
        oce_pkg::CFG_PITCH_UPPER: pitch_hi = longint'($signed(data[14:0]));
        oce_pkg::CFG_PITCH_LOWER: pitch_lo = longint'($signed(data[14:0]));
        oce_pkg::CFG_DISTANCE:    distance = longint'(data[30:0]);
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint round_q30(longint v);
      return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // The angle is folded into the right half plane and both outputs are negated back.
    function void sin_cos(input longint angle, output longint s_out, output longint c_out);
      longint z;
      longint x;
      longint y;
      longint nx;
      bit     flip;
      z = angle * 64'sd65536;
      x = longint'(oce_pkg::CORDIC_GAIN);
      y = 64'sd0;
      flip = 1'b0;
      if (z > oce_pkg::Q28_PI) z -= longint'(oce_pkg::Q28_TWO_PI);
      if (z < -oce_pkg::Q28_PI) z += longint'(oce_pkg::Q28_TWO_PI);
      if (z > oce_pkg::Q28_HALF_PI) begin
        z -= longint'(oce_pkg::Q28_PI);
        flip = 1'b1;
      end else if (z < -oce_pkg::Q28_HALF_PI) begin
        z += longint'(oce_pkg::Q28_PI);
        flip = 1'b1;
      end
      for (int i = 0; i < oce_pkg::CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z -= longint'(oce_pkg::ATAN_Q28[i]);
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z += longint'(oce_pkg::ATAN_Q28[i]);
        end
        x = nx;
      end
      s_out = flip ? -y : y;
      c_out = flip ? -x : x;
    endfunction

    function void take_frame(frame_t f);
      longint rate_step;
      longint sp;
      longint cp;
      longint sy;
      longint cy;
      longint tgt[3];
      longint dir[3];
      longint point[3];
      eye_t   e;
      rate_step = turn_rate * longint'(f.frame_time);
      pitch = clip(pitch + ((longint'(f.stick_v) * rate_step + (64'sd1 <<< 26)) >>> 27),
                   ANGLE_MIN, ANGLE_MAX);
      yaw = clip(yaw + ((longint'(f.stick_h) * rate_step + (64'sd1 <<< 26)) >>> 27),
                 ANGLE_MIN, ANGLE_MAX);
      sin_cos(pitch, sp, cp);
      sin_cos(yaw, sy, cy);
      dir[0] = round_q30(cp * sy);
      dir[1] = -sp;
      dir[2] = round_q30(cp * cy);
      tgt[0] = longint'(f.target_x);
      tgt[1] = longint'(f.target_y);
      tgt[2] = longint'(f.target_z);
      for (int k = 0; k < 3; k++) begin
        point[k] = clip(tgt[k] + round_q30(dir[k] * distance), EYE_MIN, EYE_MAX);
      end
      // Upper clamp first, so crossed limits leave the lower one in force.
      if (pitch > pitch_hi) pitch = pitch_hi;
      if (pitch < pitch_lo) pitch = pitch_lo;
      if (yaw < -oce_pkg::Q12_PI) yaw += longint'(oce_pkg::Q12_TWO_PI);
      if (yaw > oce_pkg::Q12_PI) yaw -= longint'(oce_pkg::Q12_TWO_PI);
      e.eye_x = point[0][31:0];
      e.eye_y = point[1][31:0];
      e.eye_z = point[2][31:0];
      e.pitch = pitch[15:0];
      e.yaw   = yaw[15:0];
      eyes_due.push_back(e);
    endfunction

    function void compare(string field, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        faults++;
      end
    endfunction

    function void match_eye(eye_t got);
      eye_t want;
      if (eyes_due.size() == 0) begin
        $error("eye beat with no frame pending: eye_x %0d eye_y %0d eye_z %0d",
               got.eye_x, got.eye_y, got.eye_z);
        faults++;
        return;
      end
      want = eyes_due.pop_front();
      compare("eye_x", want.eye_x, got.eye_x);
      compare("eye_y", want.eye_y, got.eye_y);
      compare("eye_z", want.eye_z, got.eye_z);
      compare("pitch_now", 32'(want.pitch), 32'(got.pitch));
      compare("yaw_now", 32'(want.yaw), 32'(got.yaw));
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  oce_pkg::cfg_idx_e              cfg_idx;
  logic [oce_pkg::CFG_DATA_W-1:0] cfg_data;
  int unsigned                    gap_pct;
  int unsigned                    stall_pct;
  int unsigned                    cycle_count;
  orbit_eye_board                 board;

  oce_in_if  frames_ch ();
  oce_out_if eyes_ch ();

  orbit_camera_eye_update_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (frames_ch),
    .out_o      (eyes_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic frame_t mk_frame(logic signed [15:0] sh, logic signed [15:0] sv,
                                      logic [15:0] ft, logic signed [31:0] tx,
                                      logic signed [31:0] ty, logic signed [31:0] tz);
    frame_t f;
    f.stick_h    = sh;
    f.stick_v    = sv;
    f.frame_time = ft;
    f.target_x   = tx;
    f.target_y   = ty;
    f.target_z   = tz;
    return f;
  endfunction

  function automatic logic signed [15:0] random_stick();
    if ($urandom_range(7) == 0) begin
      return $urandom_range(1) ? STICK_MAX : STICK_MIN;
    end
    return 16'($urandom);
  endfunction

  function automatic logic signed [31:0] random_coord();
    if ($urandom_range(3) == 0) begin
      return 32'($urandom);
    end
    return $signed($urandom) >>> 10;
  endfunction

  function automatic frame_t random_frame();
    logic [15:0] ft;
    ft = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1100));
    return mk_frame(random_stick(), random_stick(), ft,
                    random_coord(), random_coord(), random_coord());
  endfunction

  // Bits above the register width carry random data that the block must ignore.
  function automatic logic [oce_pkg::CFG_DATA_W-1:0] noisy(
      logic [oce_pkg::CFG_DATA_W-1:0] v, int w);
    logic [oce_pkg::CFG_DATA_W-1:0] keep;
    keep = (31'd1 << w) - 31'd1;
    return (31'($urandom) & ~keep) | (v & keep);
  endfunction

  task automatic write_reg(oce_pkg::cfg_idx_e idx, logic [oce_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    board.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(frame_t f);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      frames_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    frames_ch.valid            <= 1'b1;
    frames_ch.stick_horizontal <= f.stick_h;
    frames_ch.stick_vertical   <= f.stick_v;
    frames_ch.frame_time       <= f.frame_time;
    frames_ch.target_x         <= f.target_x;
    frames_ch.target_y         <= f.target_y;
    frames_ch.target_z         <= f.target_z;
    do @(posedge clk_i); while (frames_ch.ready !== 1'b1);
    board.take_frame(f);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    frames_ch.valid <= 1'b0;
    while (board.eyes_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin : eye_sink
    eye_t got;
    eyes_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      eyes_ch.ready <= ($urandom_range(99) >= stall_pct);
      @(posedge clk_i);
      if (eyes_ch.valid === 1'b1 && eyes_ch.ready === 1'b1) begin
        got.eye_x = eyes_ch.eye_x;
        got.eye_y = eyes_ch.eye_y;
        got.eye_z = eyes_ch.eye_z;
        got.pitch = eyes_ch.pitch_now;
        got.yaw   = eyes_ch.yaw_now;
        board.match_eye(got);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned rate;
    int          lim_hi;
    int          lim_lo;
    int unsigned reach;
    board = new();
    rst_ni                     = 1'b0;
    cfg_we                     = 1'b0;
    cfg_idx                    = oce_pkg::CFG_TURN_RATE;
    cfg_data                   = '0;
    frames_ch.valid            = 1'b0;
    frames_ch.stick_horizontal = '0;
    frames_ch.stick_vertical   = '0;
    frames_ch.frame_time       = '0;
    frames_ch.target_x         = '0;
    frames_ch.target_y         = '0;
    frames_ch.target_z         = '0;
    gap_pct                    = 0;
    stall_pct                  = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: rest, full-scale turns through the yaw wrap and both pitch clamps.
    send_frame(mk_frame('0, '0, '0, '0, '0, '0));
    send_frame(mk_frame(STICK_MAX, STICK_MAX, 16'hffff, COORD_MAX, COORD_MAX, COORD_MAX));
    repeat (2) send_frame(mk_frame(STICK_MAX, STICK_MAX, 16'hffff, '0, '0, '0));
    repeat (3) send_frame(mk_frame(STICK_MIN, STICK_MIN, 16'hffff,
                                   COORD_MIN, COORD_MIN, COORD_MIN));
    wait_drained();

    // Fastest turn, longest reach and crossed pitch limits.
    write_reg(oce_pkg::CFG_TURN_RATE, noisy(31'h0000ffff, 16));
    write_reg(oce_pkg::CFG_DISTANCE, 31'h7fffffff);
    write_reg(oce_pkg::CFG_PITCH_UPPER, noisy(31'(-12868), 15));
    write_reg(oce_pkg::CFG_PITCH_LOWER, noisy(31'd12868, 15));
    send_frame(mk_frame(STICK_MAX, STICK_MIN, 16'hffff, COORD_MAX, COORD_MIN, COORD_MAX));
    send_frame(mk_frame(STICK_MIN, STICK_MAX, 16'hffff, COORD_MIN, COORD_MAX, COORD_MIN));
    send_frame(mk_frame(STICK_MAX, STICK_MAX, 16'hffff, '0, '0, '0));
    send_frame(mk_frame(16'sd1, -16'sd1, 16'd1, 32'sd1, -32'sd1, '0));
    wait_drained();

    // Limits at the ends of their format, then no turn and no reach.
    write_reg(oce_pkg::CFG_PITCH_UPPER, noisy(31'd16383, 15));
    write_reg(oce_pkg::CFG_PITCH_LOWER, noisy(31'(-16384), 15));
    write_reg(oce_pkg::CFG_TURN_RATE, noisy(31'd0, 16));
    write_reg(oce_pkg::CFG_DISTANCE, 31'd0);
    send_frame(mk_frame(STICK_MAX, STICK_MAX, 16'hffff, COORD_MAX, COORD_MIN, '0));
    wait_drained();
    write_reg(oce_pkg::CFG_TURN_RATE, noisy(31'h0000ffff, 16));
    send_frame(mk_frame(STICK_MAX, STICK_MAX, 16'hffff, COORD_MIN, COORD_MAX, 32'sd1));
    send_frame(mk_frame(STICK_MIN, STICK_MIN, 16'hffff, -32'sd1, '0, COORD_MAX));
    send_frame(mk_frame(STICK_MIN, STICK_MAX, 16'h8000, '0, COORD_MIN, COORD_MIN));

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      rate = ($urandom_range(3) == 0) ? $urandom_range(16'hffff) : $urandom_range(2048);
      if ($urandom_range(3) == 0) begin
        lim_hi = int'($urandom_range(32767)) - 16384;
        lim_lo = int'($urandom_range(32767)) - 16384;
      end else begin
        lim_hi = int'($urandom_range(12868));
        lim_lo = -int'($urandom_range(12868));
      end
      reach = ($urandom_range(3) == 0) ? $urandom_range(31'h7fffffff)
                                       : $urandom_range(32'h00200000);
      write_reg(oce_pkg::CFG_TURN_RATE, noisy(31'(rate), 16));
      write_reg(oce_pkg::CFG_PITCH_UPPER, noisy(31'(lim_hi), 15));
      write_reg(oce_pkg::CFG_PITCH_LOWER, noisy(31'(lim_lo), 15));
      write_reg(oce_pkg::CFG_DISTANCE, 31'(reach));
      case (phase % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 84;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 84;
        end
        default: begin
          gap_pct   = 15;
          stall_pct = 15;
        end
      endcase
      repeat (FRAMES_PER_PHASE) send_frame(random_frame());
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
